FILE: src/gri_pkg.sv
// Shared types and constants for the gyro rate integrator.
`timescale 1ns / 1ps

package gri_pkg;

  localparam int ACC_W        = 48;
  localparam int HEAD_W       = 32;
  localparam int RAW_FIELD_W  = 10;
  localparam int CMD_W        = 2;
  localparam int DEADBAND_W   = 8;
  localparam int LIMIT_W      = 10;
  localparam int PERIOD_W     = 8;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_INDEX_W  = 2;
  localparam int MS_PER_S     = 1000;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd10;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 10'd200;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 8'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_RESTART = 2'd2
  } gri_cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEADBAND = 2'd0,
    REG_LIMIT    = 2'd1,
    REG_PERIOD   = 2'd2
  } gri_reg_t;

  typedef struct packed {
    logic valid_res;
    logic ready_res;
  } gri_flags_t;

endpackage

FILE: src/gri_core.sv
// Calibration, bias removal, deadband and saturating angle accumulator.
`timescale 1ns / 1ps

module gri_core #(
  parameter int CAL_SAMPLES = 25,
  parameter int RAW_W       = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gri_pkg::CMD_W-1:0]             in_cmd,
  input  logic [RAW_W-1:0]                      in_raw,
  input  logic [gri_pkg::DEADBAND_W-1:0]        deadband_rate,
  input  logic [gri_pkg::LIMIT_W-1:0]           valid_rate_limit,
  input  logic [gri_pkg::PERIOD_W-1:0]          period_ms,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gri_pkg::ACC_W-1:0]      out_acc,
  output gri_pkg::gri_flags_t                   out_flags
);

  localparam int CW     = $clog2(CAL_SAMPLES + 1);
  localparam int BW     = $clog2(CAL_SAMPLES * ((1 << RAW_W) - 1) + 1);
  localparam int LIM_W  = gri_pkg::LIMIT_W + CW;
  localparam int DB_W   = gri_pkg::DEADBAND_W + CW;
  localparam int CMP_W  = (BW > LIM_W) ? BW : LIM_W;
  localparam int DW     = BW + 1 + gri_pkg::PERIOD_W + 1;
  localparam int AW     = gri_pkg::ACC_W;
  localparam int SUM_W  = AW + 1;
  localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  logic [CW-1:0]           cal_count, cal_count_next;
  logic [BW-1:0]           bias_sum, bias_sum_next;
  logic                    ready_flag, ready_flag_next;
  logic                    last_rate_ok, last_rate_ok_next;
  logic signed [AW-1:0]    angle_acc, angle_acc_next;

  logic                    accept;
  logic [BW-1:0]           raw_scaled;
  logic signed [BW:0]      rate;
  logic [BW-1:0]           mag;
  logic [LIM_W-1:0]        lim_scaled;
  logic [DB_W-1:0]         db_scaled;
  logic                    rate_ok;
  logic                    in_band;
  logic signed [BW:0]      eff_rate;
  logic signed [DW-1:0]    delta;
  logic signed [SUM_W-1:0] sum;
  logic signed [AW-1:0]    sum_sat;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign raw_scaled = BW'(in_raw * CAL_SAMPLES);
  assign rate       = $signed({1'b0, raw_scaled}) - $signed({1'b0, bias_sum});
  assign mag        = rate[BW] ? BW'(-rate) : rate[BW-1:0];
  assign lim_scaled = LIM_W'(valid_rate_limit * CAL_SAMPLES);
  assign db_scaled  = DB_W'(deadband_rate * CAL_SAMPLES);
  assign rate_ok    = CMP_W'(mag) <= CMP_W'(lim_scaled);
  assign in_band    = CMP_W'(mag) < CMP_W'(db_scaled);
  assign eff_rate   = in_band ? '0 : rate;
  assign delta      = DW'(eff_rate) * DW'($signed({1'b0, period_ms}));
  assign sum        = SUM_W'(angle_acc) + SUM_W'(delta);

  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sum_sat = sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum[AW-1:0];
    end
  end

  always_comb begin
    cal_count_next    = cal_count;
    bias_sum_next     = bias_sum;
    ready_flag_next   = ready_flag;
    last_rate_ok_next = last_rate_ok;
    angle_acc_next    = angle_acc;
    unique case (gri_pkg::gri_cmd_t'(in_cmd))
      gri_pkg::CMD_SAMPLE: begin
        if (cal_count < CW'(CAL_SAMPLES)) begin
          bias_sum_next  = bias_sum + BW'(in_raw);
          cal_count_next = cal_count + 1'b1;
        end else begin
          last_rate_ok_next = rate_ok;
          angle_acc_next    = sum_sat;
          ready_flag_next   = 1'b1;
        end
      end
      gri_pkg::CMD_CLEAR: begin
        angle_acc_next = '0;
      end
      gri_pkg::CMD_RESTART: begin
        cal_count_next    = '0;
        bias_sum_next     = '0;
        ready_flag_next   = 1'b0;
        last_rate_ok_next = 1'b0;
        angle_acc_next    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count    <= '0;
      bias_sum     <= '0;
      ready_flag   <= 1'b0;
      last_rate_ok <= 1'b0;
      angle_acc    <= '0;
    end else if (accept) begin
      cal_count    <= cal_count_next;
      bias_sum     <= bias_sum_next;
      ready_flag   <= ready_flag_next;
      last_rate_ok <= last_rate_ok_next;
      angle_acc    <= angle_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_acc             <= angle_acc_next;
      out_flags.ready_res <= ready_flag_next;
      out_flags.valid_res <= ready_flag_next && last_rate_ok_next;
    end
  end

endmodule

FILE: src/gri_div.sv
// Pipelined divide of the accumulator by a constant, truncated and saturated.
`timescale 1ns / 1ps

module gri_div #(
  parameter int DIVISOR = 25000
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [gri_pkg::ACC_W-1:0]      in_acc,
  input  gri_pkg::gri_flags_t                   in_flags,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gri_pkg::HEAD_W-1:0]     out_heading,
  output gri_pkg::gri_flags_t                   out_flags
);

  localparam int AW    = gri_pkg::ACC_W;
  localparam int HW    = gri_pkg::HEAD_W;
  localparam int L     = $clog2(DIVISOR);
  localparam int SHIFT = AW + L;
  localparam int MW    = AW + 1;
  localparam int PW    = AW + MW;
  localparam int QW    = PW - SHIFT;
  localparam int NCH   = 3;
  localparam int CH    = AW / NCH;
  localparam int ML    = (MW + 1) / 2;
  localparam int MH    = MW - ML;
  localparam int RWID  = CH + MW;
  localparam logic [127:0] MUL_WIDE =
    ((128'd1 << SHIFT) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
  localparam logic [MW-1:0] MUL    = MUL_WIDE[MW-1:0];
  localparam logic [ML-1:0] MUL_LO = MUL[ML-1:0];
  localparam logic [MH-1:0] MUL_HI = MUL[MW-1:ML];
  localparam logic [QW-1:0] POS_LIM = QW'({1'b0, {(HW-1){1'b1}}});
  localparam logic [QW-1:0] NEG_LIM = QW'({1'b1, {(HW-1){1'b0}}});
  localparam logic signed [HW-1:0] HEAD_MAX = {1'b0, {(HW-1){1'b1}}};
  localparam logic signed [HW-1:0] HEAD_MIN = {1'b1, {(HW-1){1'b0}}};

  logic                  v1, v2, v3, v4;
  logic                  en1, en2, en3, en4, en5;
  logic [AW-1:0]         mag1;
  logic                  neg1, neg2, neg3, neg4;
  gri_pkg::gri_flags_t   fl1, fl2, fl3, fl4;
  logic [CH+ML-1:0]      pp_lo [NCH];
  logic [CH+MH-1:0]      pp_hi [NCH];
  logic [RWID-1:0]       row [NCH];
  logic [QW-1:0]         quot;
  logic [PW-1:0]         total;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign total = PW'(row[0]) + (PW'(row[1]) << CH) + (PW'(row[2]) << (2 * CH));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mag1 <= in_acc[AW-1] ? AW'(-in_acc) : in_acc;
      neg1 <= in_acc[AW-1];
      fl1  <= in_flags;
    end
    if (en2) begin
      for (int i = 0; i < NCH; i++) begin
        pp_lo[i] <= mag1[i*CH +: CH] * MUL_LO;
        pp_hi[i] <= mag1[i*CH +: CH] * MUL_HI;
      end
      neg2 <= neg1;
      fl2  <= fl1;
    end
    if (en3) begin
      for (int i = 0; i < NCH; i++) begin
        row[i] <= RWID'(pp_lo[i]) + (RWID'(pp_hi[i]) << ML);
      end
      neg3 <= neg2;
      fl3  <= fl2;
    end
    if (en4) begin
      quot <= total[PW-1:SHIFT];
      neg4 <= neg3;
      fl4  <= fl3;
    end
    if (en5) begin
      if (neg4) begin
        out_heading <= (quot > NEG_LIM) ? HEAD_MIN : -$signed(quot[HW-1:0]);
      end else begin
        out_heading <= (quot > POS_LIM) ? HEAD_MAX : $signed(quot[HW-1:0]);
      end
      out_flags <= fl4;
    end
  end

endmodule

FILE: src/gyro_rate_integrator.sv
// Top level of the gyro rate integrator: register file, core and heading divider.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid / tready    tdata: raw_rate, tuser: command
//   m_*      out  tvalid / tready    tdata: heading,  tuser: ready_res, valid_res
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One word accepted per cycle unless s_tready is low; each word yields one result after
// the accumulator stage plus five divider stages for the constant reciprocal multiply.
// The accumulator loop closes through one register, which sets the one-word-per-cycle rate.
// Reset clears calibration, angle and the pipeline valids; cfg registers return to defaults.
// Stalls on m_tready fill empty stages first, then hold s_tready low.
`timescale 1ns / 1ps

module gyro_rate_integrator #(
  parameter int CAL_SAMPLES = 25,
  parameter int RAW_BITS    = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,   // [9:0] raw_rate
  input  logic [gri_pkg::CMD_W-1:0]           s_tuser,   // [1:0] command
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gri_pkg::HEAD_W-1:0]          m_tdata,   // [31:0] heading
  output logic [1:0]                          m_tuser,   // [0] ready_res, [1] valid_res
  input  logic                                cfg_we,
  input  logic [gri_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gri_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int RAW_W = (RAW_BITS < gri_pkg::RAW_FIELD_W) ? RAW_BITS : gri_pkg::RAW_FIELD_W;
  localparam int DIVISOR = CAL_SAMPLES * gri_pkg::MS_PER_S;

  logic [gri_pkg::DEADBAND_W-1:0]       deadband_rate;
  logic [gri_pkg::LIMIT_W-1:0]          valid_rate_limit;
  logic [gri_pkg::PERIOD_W-1:0]         period_ms;

  logic                                 core_valid;
  logic                                 core_ready;
  logic signed [gri_pkg::ACC_W-1:0]     core_acc;
  gri_pkg::gri_flags_t                  core_flags;
  logic signed [gri_pkg::HEAD_W-1:0]    heading;
  gri_pkg::gri_flags_t                  res_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_rate    <= gri_pkg::DEADBAND_RESET;
      valid_rate_limit <= gri_pkg::LIMIT_RESET;
      period_ms        <= gri_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (gri_pkg::gri_reg_t'(cfg_index))
        gri_pkg::REG_DEADBAND: deadband_rate    <= cfg_data[gri_pkg::DEADBAND_W-1:0];
        gri_pkg::REG_LIMIT:    valid_rate_limit <= cfg_data[gri_pkg::LIMIT_W-1:0];
        gri_pkg::REG_PERIOD:   period_ms        <= cfg_data[gri_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gri_core #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .RAW_W       (RAW_W)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_cmd           (s_tuser),
    .in_raw           (s_tdata[RAW_W-1:0]),
    .deadband_rate    (deadband_rate),
    .valid_rate_limit (valid_rate_limit),
    .period_ms        (period_ms),
    .out_valid        (core_valid),
    .out_ready        (core_ready),
    .out_acc          (core_acc),
    .out_flags        (core_flags)
  );

  gri_div #(
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (core_valid),
    .in_ready    (core_ready),
    .in_acc      (core_acc),
    .in_flags    (core_flags),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_heading (heading),
    .out_flags   (res_flags)
  );

  assign m_tdata = heading;
  assign m_tuser = {res_flags.valid_res, res_flags.ready_res};

endmodule

FILE: sim/gyro_rate_integrator_tb.sv
// Self-checking testbench for gyro_rate_integrator: bias calibration, heading, status flags.
`timescale 1ns / 1ps

module gyro_rate_integrator_tb;

  localparam int CAL_SAMPLES = 25;
  localparam int RAW_BITS    = 10;
  localparam int RAW_W       = gri_pkg::RAW_FIELD_W;
  localparam int CFG_W       = gri_pkg::CFG_DATA_W;
  localparam logic [gri_pkg::CMD_W-1:0]       CMD_UNUSED = 2'd3;
  localparam logic [gri_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint ACC_TOP     = (longint'(1) <<< (gri_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_BOTTOM  = -ACC_TOP - 1;
  localparam longint HEAD_TOP    = (longint'(1) <<< (gri_pkg::HEAD_W - 1)) - 1;
  localparam longint HEAD_BOTTOM = -HEAD_TOP - 1;
  localparam longint DEG_SCALE   = longint'(CAL_SAMPLES) * longint'(gri_pkg::MS_PER_S);

  typedef struct packed {
    logic signed [gri_pkg::HEAD_W-1:0] heading;
    logic                              ready_res;
    logic                              valid_res;
  } heading_word_t;

  class heading_scoreboard;
    int unsigned   deadband;
    int unsigned   rate_limit;
    int unsigned   period;
    int unsigned   cal_taken;
    int unsigned   bias_acc;
    bit            ready;
    bit            rate_ok;
    longint        angle;
    heading_word_t due_q[$];
    int unsigned   mismatches;
    int unsigned   results_checked;

    function new();
      deadband        = 32'(gri_pkg::DEADBAND_RESET);
      rate_limit      = 32'(gri_pkg::LIMIT_RESET);
      period          = 32'(gri_pkg::PERIOD_RESET);
      cal_taken       = 0;
      bias_acc        = 0;
      ready           = 1'b0;
      rate_ok         = 1'b0;
      angle           = 0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void write_reg(logic [gri_pkg::CFG_INDEX_W-1:0] idx,
                            logic [gri_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        gri_pkg::REG_DEADBAND: deadband = 32'(value[gri_pkg::DEADBAND_W-1:0]);
        gri_pkg::REG_LIMIT:    rate_limit = 32'(value[gri_pkg::LIMIT_W-1:0]);
        gri_pkg::REG_PERIOD:   period = 32'(value[gri_pkg::PERIOD_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_word(logic [gri_pkg::CMD_W-1:0] cmd, logic [RAW_W-1:0] raw);
      int unsigned   raw_used;
      longint        rate;
      longint        mag;
      longint        sum;
      longint        deg;
      heading_word_t e;
      raw_used = 32'(raw) & ((32'd1 << RAW_BITS) - 32'd1);
      case (cmd)
        gri_pkg::CMD_SAMPLE: begin
          if (cal_taken < CAL_SAMPLES) begin
            bias_acc += raw_used;
            cal_taken++;
          end else begin
            rate = longint'(raw_used) * longint'(CAL_SAMPLES) - longint'(bias_acc);
            mag = (rate < 0) ? -rate : rate;
            rate_ok = (mag <= longint'(rate_limit) * longint'(CAL_SAMPLES));
            if (mag < longint'(deadband) * longint'(CAL_SAMPLES))
              rate = 0;
            sum = angle + rate * longint'(period);
            if (sum > ACC_TOP) sum = ACC_TOP;
            if (sum < ACC_BOTTOM) sum = ACC_BOTTOM;
            angle = sum;
            ready = 1'b1;
          end
        end
        gri_pkg::CMD_CLEAR: angle = 0;
        gri_pkg::CMD_RESTART: begin
          cal_taken = 0;
          bias_acc  = 0;
          ready     = 1'b0;
          rate_ok   = 1'b0;
          angle     = 0;
        end
        default: ;
      endcase
      deg = angle / DEG_SCALE;
      if (deg > HEAD_TOP) deg = HEAD_TOP;
      if (deg < HEAD_BOTTOM) deg = HEAD_BOTTOM;
      e.heading   = deg[gri_pkg::HEAD_W-1:0];
      e.ready_res = ready;
      e.valid_res = ready && rate_ok;
      due_q.push_back(e);
    endfunction

    function void check_result(logic [gri_pkg::HEAD_W-1:0] head, logic [1:0] flags);
      heading_word_t e;
      results_checked++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: heading %0d ready %0b valid %0b",
                   $signed(head), flags[0], flags[1]);
        return;
      end
      e = due_q.pop_front();
      if (head !== e.heading || flags[0] !== e.ready_res || flags[1] !== e.valid_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected heading %0d ready %0b valid %0b, got %0d %0b %0b",
                   results_checked, e.heading, e.ready_res, e.valid_res,
                   $signed(head), flags[0], flags[1]);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [15:0]                     s_tdata;   // [9:0] raw_rate
  logic [gri_pkg::CMD_W-1:0]       s_tuser;   // [1:0] command
  logic                            m_tvalid;
  logic                            m_tready;
  logic [gri_pkg::HEAD_W-1:0]      m_tdata;   // [31:0] heading
  logic [1:0]                      m_tuser;   // [0] ready_res, [1] valid_res
  logic                            cfg_we;
  logic [gri_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gri_pkg::CFG_DATA_W-1:0]  cfg_data;

  heading_scoreboard sb = new();
  bit          quiet = 1'b0;
  int unsigned n_samples, n_clears, n_restarts, n_unused, n_settings;

  gyro_rate_integrator #(
    .CAL_SAMPLES(CAL_SAMPLES),
    .RAW_BITS   (RAW_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [RAW_W-1:0] clamp_raw(int v);
    if (v < 0) return '0;
    if (v > (1 << RAW_W) - 1) return '1;
    return v[RAW_W-1:0];
  endfunction

  task automatic push_word(logic [gri_pkg::CMD_W-1:0] cmd, logic [RAW_W-1:0] raw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(16 - RAW_W){1'b0}}, raw};
    do @(posedge clk); while (!s_tready);
    sb.note_word(cmd, raw);
    case (cmd)
      gri_pkg::CMD_SAMPLE:  n_samples++;
      gri_pkg::CMD_CLEAR:   n_clears++;
      gri_pkg::CMD_RESTART: n_restarts++;
      default:              n_unused++;
    endcase
  endtask

  task automatic set_reg(logic [gri_pkg::CFG_INDEX_W-1:0] idx,
                         logic [gri_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned center;
    int unsigned cal_left;
    int unsigned pick;
    int          span;
    int          offset;
    center   = $urandom_range(0, 1023);
    cal_left = 0;
    if ($urandom_range(0, 1) == 1) begin
      push_word(gri_pkg::CMD_RESTART, RAW_W'($urandom_range(0, 1023)));
      cal_left = CAL_SAMPLES;
    end
    for (int unsigned k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      if (cal_left > 0 && pick < 90) begin
        offset = ($urandom_range(0, 1) == 1) ? 0 : int'($urandom_range(0, 4)) - 2;
        push_word(gri_pkg::CMD_SAMPLE, clamp_raw(int'(center) + offset));
        cal_left--;
      end else if (pick < 84) begin
        case ($urandom_range(0, 3))
          0: begin
            span   = int'(sb.deadband) + 2;
            offset = int'($urandom_range(0, 2 * span)) - span;
          end
          1: begin
            offset = int'(sb.rate_limit + $urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) offset = -offset;
          end
          2: offset = int'($urandom_range(0, 500)) - 250;
          default: offset = int'($urandom_range(0, 1023)) - int'(center);
        endcase
        push_word(gri_pkg::CMD_SAMPLE, clamp_raw(int'(center) + offset));
      end else if (pick < 92) begin
        push_word(gri_pkg::CMD_CLEAR, RAW_W'($urandom_range(0, 1023)));
      end else if (pick < 99) begin
        push_word(CMD_UNUSED, RAW_W'($urandom_range(0, 1023)));
      end else begin
        push_word(gri_pkg::CMD_RESTART, RAW_W'($urandom_range(0, 1023)));
        center   = $urandom_range(0, 1023);
        cal_left = CAL_SAMPLES;
      end
    end
  endtask

  initial begin : result_sink
    bit long_hold_done;
    long_hold_done = 1'b0;
    m_tready <= 1'b0;
    repeat (10) @(posedge clk);
    forever begin
      if (!long_hold_done && !quiet && sb.results_checked >= 150) begin
        long_hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      if (m_tvalid)
        sb.check_result(m_tdata, m_tuser);
    end
  end

  initial begin : stimulus
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= gri_pkg::CMD_SAMPLE;
    cfg_we    <= 1'b0;
    cfg_index <= gri_pkg::REG_DEADBAND;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // status and clear before any calibration
    push_word(CMD_UNUSED, 10'h3FF);
    push_word(gri_pkg::CMD_CLEAR, 10'h000);
    push_word(gri_pkg::CMD_SAMPLE, 10'h000);
    push_word(gri_pkg::CMD_SAMPLE, 10'h3FF);
    push_word(gri_pkg::CMD_CLEAR, 10'h155);
    for (int i = 0; i < CAL_SAMPLES - 2; i++)
      push_word(gri_pkg::CMD_SAMPLE, 10'd20);
    // first integrated words: out of limit, negative, inside deadband, just past it
    push_word(gri_pkg::CMD_SAMPLE, 10'h3FF);
    push_word(gri_pkg::CMD_SAMPLE, 10'h000);
    push_word(gri_pkg::CMD_SAMPLE, 10'd59);
    push_word(gri_pkg::CMD_SAMPLE, 10'd69);
    push_word(gri_pkg::CMD_SAMPLE, 10'd70);
    push_word(CMD_UNUSED, 10'h2AA);
    push_word(gri_pkg::CMD_CLEAR, 10'h3FF);
    push_word(gri_pkg::CMD_SAMPLE, 10'h3FF);
    push_word(gri_pkg::CMD_RESTART, 10'h3FF);
    push_word(gri_pkg::CMD_SAMPLE, 10'h200);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin
          set_reg(gri_pkg::REG_DEADBAND, 10'd0);
          set_reg(gri_pkg::REG_LIMIT, 10'd0);
          set_reg(gri_pkg::REG_PERIOD, 10'd1);
        end
        1: begin
          set_reg(gri_pkg::REG_DEADBAND, 10'h3FF);
          set_reg(gri_pkg::REG_LIMIT, 10'd1023);
          set_reg(gri_pkg::REG_PERIOD, 10'd255);
          set_reg(REG_UNUSED, CFG_W'($urandom_range(0, 1023)));
        end
        2: begin
          set_reg(gri_pkg::REG_DEADBAND, 10'd3);
          set_reg(gri_pkg::REG_LIMIT, 10'd20);
          set_reg(gri_pkg::REG_PERIOD, 10'd0);
        end
        7: begin
          set_reg(gri_pkg::REG_DEADBAND, CFG_W'(gri_pkg::DEADBAND_RESET));
          set_reg(gri_pkg::REG_LIMIT, CFG_W'(gri_pkg::LIMIT_RESET));
          set_reg(gri_pkg::REG_PERIOD, CFG_W'(gri_pkg::PERIOD_RESET));
        end
        default: begin
          set_reg(gri_pkg::REG_DEADBAND, CFG_W'($urandom_range(0, 40)));
          set_reg(gri_pkg::REG_LIMIT, CFG_W'($urandom_range(0, 1023)));
          set_reg(gri_pkg::REG_PERIOD, CFG_W'($urandom_range(0, 255)));
        end
      endcase
      cfg_we <= 1'b0;
      n_settings++;
      quiet = (p == 3 || p == 7);
      @(posedge clk);
      run_phase(240);
    end

    drain();
    $display("covered %0d words: %0d rate samples, %0d clears, %0d restarts, %0d unused",
             n_samples + n_clears + n_restarts + n_unused, n_samples, n_clears, n_restarts,
             n_unused);
    $display("%0d results compared over %0d register settings, %0d mismatches",
             sb.results_checked, n_settings + 1, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("gyro_rate_integrator_tb: clean");
    end else begin
      $display("gyro_rate_integrator_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout with %0d results still expected", sb.pending());
    $display("gyro_rate_integrator_tb: errors");
    $finish;
  end

endmodule
